// ===== design/tdsf_pkg.sv =====
// Shared types and constants for the time-of-flight distance spike filter.
// Used by tdsf_step and tof_distance_spike_filter_unit; no dependencies.
`timescale 1ns / 1ps

package tdsf_pkg;

  localparam int unsigned Window   = 3;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned DistW    = 13;
  localparam int unsigned RunW     = 4;
  localparam int unsigned PtrW     = 2;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DistW-1:0]    FarMm          = 13'd8190;
  localparam logic [DistW-1:0]    SpikeJumpRst   = 13'd400;
  localparam logic [DistW-1:0]    NearLimitRst   = 13'd1500;
  localparam logic [RunW-1:0]     HoldCountRst   = 4'd2;
  localparam logic [TimeoutW-1:0] StaleTimeoutRst = 16'd200;
  localparam logic [RunW-1:0]     RunMax         = 4'd15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPIKE_JUMP    = 2'd0,
    REG_NEAR_LIMIT    = 2'd1,
    REG_HOLD_COUNT    = 2'd2,
    REG_STALE_TIMEOUT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DistW-1:0]    spike_jump;
    logic [DistW-1:0]    near_limit;
    logic [RunW-1:0]     hold_count;
    logic [TimeoutW-1:0] stale_timeout;
  } cfg_t;

  typedef struct packed {
    logic [Window-1:0][DistW-1:0] ring;
    logic [PtrW-1:0]              ptr;
    logic [DistW-1:0]             last_good;
    logic [RunW-1:0]              spike_run;
    logic [TimeW-1:0]             last_seen;
    logic [DistW-1:0]             reported;
  } chan_state_t;

  typedef struct packed {
    logic [DistW-1:0] dist_mm;
    logic             held;
    logic             stale;
  } result_t;

  function automatic logic [DistW-1:0] median3(input logic [DistW-1:0] a,
                                               input logic [DistW-1:0] b,
                                               input logic [DistW-1:0] c);
    logic ab;
    logic bc;
    logic ac;
    logic [DistW-1:0] m;
    ab = (a > b);
    bc = (b > c);
    ac = (a > c);
    if (ab == bc) begin
      m = b;
    end else if (ab != ac) begin
      m = a;
    end else begin
      m = c;
    end
    return m;
  endfunction

endpackage

// ===== design/tof_distance_spike_filter_unit.sv =====
// An input transfer is registered in the input stage, and its result in the
// result stage, which drives the outputs. Throughput: one poll per cycle unless
// the output stalls; the per-channel state in flip-flops is read and updated in
// the same cycle, so polls of one channel may follow back to back.
// Reset: asynchronous, active low; clears the stage valid flags, loads default
// settings, and returns every channel to zero ring, far last-good/report,
// never seen. Depends on tdsf_pkg and tdsf_step.
`timescale 1ns / 1ps

module tof_distance_spike_filter_unit #(
  parameter int unsigned CHANNELS = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tdsf_pkg::ChanW-1:0]        chan_i,
  input  logic                              sample_valid_i,
  input  logic [tdsf_pkg::DistW-1:0]        raw_mm_i,
  input  logic                              median_mode_i,
  input  logic [tdsf_pkg::TimeW-1:0]        now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tdsf_pkg::ChanW-1:0]        out_chan_o,
  output logic [tdsf_pkg::DistW-1:0]        dist_mm_o,
  output logic                              spike_held_o,
  output logic                              stale_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tdsf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tdsf_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tdsf_pkg::*;

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t                        cfg_q;
  chan_state_t [CHANNELS-1:0]  state_q;
  chan_state_t                 cur_state;
  chan_state_t                 nxt_state;
  result_t                     step_res;
  result_t                     res_d;

  logic                        in_valid_q;
  logic [ChanW-1:0]            chan_q;
  logic                        sample_valid_q;
  logic [DistW-1:0]            raw_mm_q;
  logic                        median_mode_q;
  logic [TimeW-1:0]            now_ms_q;

  logic                        out_valid_q;
  logic [ChanW-1:0]            out_chan_q;
  result_t                     res_q;

  logic                        advance;
  logic                        fire;
  logic                        in_range;
  logic [ChIdxW-1:0]           ch_idx;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_range   = (32'(chan_q) < CHANNELS);
  assign ch_idx     = ChIdxW'(chan_q);
  assign cur_state  = in_range ? state_q[ch_idx] : '0;

  tdsf_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (cur_state),
    .sample_valid_i (sample_valid_q),
    .raw_mm_i       (raw_mm_q),
    .median_mode_i  (median_mode_q),
    .now_ms_i       (now_ms_q),
    .state_o        (nxt_state),
    .result_o       (step_res)
  );

  assign res_d = in_range ? step_res : '{dist_mm: FarMm, held: 1'b0, stale: 1'b0};

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spike_jump    <= SpikeJumpRst;
      cfg_q.near_limit    <= NearLimitRst;
      cfg_q.hold_count    <= HoldCountRst;
      cfg_q.stale_timeout <= StaleTimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SPIKE_JUMP:    cfg_q.spike_jump    <= cfg_data_i[DistW-1:0];
        REG_NEAR_LIMIT:    cfg_q.near_limit    <= cfg_data_i[DistW-1:0];
        REG_HOLD_COUNT:    cfg_q.hold_count    <= cfg_data_i[RunW-1:0];
        REG_STALE_TIMEOUT: cfg_q.stale_timeout <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      chan_q         <= chan_i;
      sample_valid_q <= sample_valid_i;
      raw_mm_q       <= raw_mm_i;
      median_mode_q  <= median_mode_i;
      now_ms_q       <= now_ms_i;
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        state_q[c].ring      <= '0;
        state_q[c].ptr       <= '0;
        state_q[c].last_good <= FarMm;
        state_q[c].spike_run <= '0;
        state_q[c].last_seen <= '0;
        state_q[c].reported  <= FarMm;
      end
    end else if (fire && in_range) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (ch_idx == ChIdxW'(c)) begin
          state_q[c] <= nxt_state;
        end
      end
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_chan_q <= chan_q;
      res_q      <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_chan_o   = out_chan_q;
  assign dist_mm_o    = res_q.dist_mm;
  assign spike_held_o = res_q.held;
  assign stale_o      = res_q.stale;

endmodule

// ===== design/tdsf_step.sv =====
// Per-poll update of one channel: median ring, spike hold and stale timeout.
// Combinational; depends on tdsf_pkg.
`timescale 1ns / 1ps

module tdsf_step (
  input  tdsf_pkg::cfg_t                     cfg_i,
  input  tdsf_pkg::chan_state_t              state_i,
  input  logic                               sample_valid_i,
  input  logic [tdsf_pkg::DistW-1:0]         raw_mm_i,
  input  logic                               median_mode_i,
  input  logic [tdsf_pkg::TimeW-1:0]         now_ms_i,
  output tdsf_pkg::chan_state_t              state_o,
  output tdsf_pkg::result_t                  result_o
);
  import tdsf_pkg::*;

  logic [PtrW-1:0]              ptr_cur;
  logic [PtrW-1:0]              ptr_inc;
  logic [PtrW-1:0]              ptr_nxt;
  logic [Window-1:0][DistW-1:0] ring_new;
  logic [DistW-1:0]             med;
  logic                         rise;
  logic                         spike;
  logic [RunW-1:0]              run_inc;
  logic [TimeW-1:0]             age;
  logic                         timed_out;

  always_comb begin
    ptr_cur = (32'(state_i.ptr) >= Window) ? '0 : state_i.ptr;
    ptr_inc = ptr_cur + 1'b1;
    ptr_nxt = (32'(ptr_inc) >= Window) ? '0 : ptr_inc;
    for (int i = 0; i < Window; i++) begin
      ring_new[i] = (32'(ptr_cur) == i) ? raw_mm_i : state_i.ring[i];
    end
    med = median3(ring_new[0], ring_new[1], ring_new[2]);
  end

  assign rise      = (raw_mm_i > state_i.last_good) &&
                     ((raw_mm_i - state_i.last_good) > cfg_i.spike_jump);
  assign spike     = rise && (state_i.last_good < cfg_i.near_limit);
  assign run_inc   = (state_i.spike_run == RunMax) ? RunMax : state_i.spike_run + 1'b1;
  assign age       = now_ms_i - state_i.last_seen;
  assign timed_out = (state_i.last_seen != '0) && (age > TimeW'(cfg_i.stale_timeout));

  always_comb begin
    state_o  = state_i;
    result_o = '{dist_mm: state_i.reported, held: 1'b0, stale: 1'b0};
    if (sample_valid_i) begin
      if (median_mode_i) begin
        state_o.ring      = ring_new;
        state_o.ptr       = ptr_nxt;
        state_o.last_good = med;
        result_o.dist_mm  = med;
      end else if (spike) begin
        state_o.spike_run = run_inc;
        if (run_inc <= cfg_i.hold_count) begin
          result_o.dist_mm = state_i.last_good;
          result_o.held    = 1'b1;
        end else begin
          state_o.last_good = raw_mm_i;
          result_o.dist_mm  = raw_mm_i;
        end
      end else begin
        state_o.spike_run = '0;
        state_o.last_good = raw_mm_i;
        result_o.dist_mm  = raw_mm_i;
      end
      state_o.reported  = result_o.dist_mm;
      state_o.last_seen = now_ms_i;
    end else if (timed_out) begin
      state_o.reported = FarMm;
      result_o.dist_mm = FarMm;
      result_o.stale   = 1'b1;
    end
  end

endmodule

// ===== verif/tb_tof_distance_spike_filter_unit.sv =====
// Self-checking testbench for tof_distance_spike_filter_unit: a directed table and
// then random poll streams under several filter settings, each checked by a predictor.
// Depends on tdsf_pkg and the filter RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_tof_distance_spike_filter_unit;
  import tdsf_pkg::*;

  localparam int NumChan      = 5;
  localparam int DirRows      = 25;
  localparam int Phases       = 8;
  localparam int PollsPerPhase = 210;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic             sv;
    logic [DistW-1:0] raw;
    logic             med;
    logic [TimeW-1:0] now;
  } poll_t;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [DistW-1:0] dist_mm;
    logic             held;
    logic             stale;
  } report_t;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic             sv;
    logic [DistW-1:0] raw;
    logic             med;
    logic [TimeW-1:0] now;
    logic             typed;
    logic [DistW-1:0] dist_mm;
    logic             held;
    logic             stale;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ChanW-1:0]    chan_i = '0;
  logic                sample_valid_i = 1'b0;
  logic [DistW-1:0]    raw_mm_i = '0;
  logic                median_mode_i = 1'b0;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ChanW-1:0]    out_chan_o;
  logic [DistW-1:0]    dist_mm_o;
  logic                spike_held_o;
  logic                stale_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tof_distance_spike_filter_unit #(
    .CHANNELS(NumChan)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .chan_i        (chan_i),
    .sample_valid_i(sample_valid_i),
    .raw_mm_i      (raw_mm_i),
    .median_mode_i (median_mode_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_chan_o    (out_chan_o),
    .dist_mm_o     (dist_mm_o),
    .spike_held_o  (spike_held_o),
    .stale_o       (stale_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Filter settings and per-channel state as the predictor sees them
  logic [DistW-1:0]    jump_lim;
  logic [DistW-1:0]    near_lim;
  logic [RunW-1:0]     hold_max;
  logic [TimeoutW-1:0] timeout_ms;
  logic [DistW-1:0]    ring_mm [NumChan][Window];
  logic [PtrW-1:0]     ring_wr [NumChan];
  logic [DistW-1:0]    good_mm [NumChan];
  logic [RunW-1:0]     run_len [NumChan];
  logic [TimeW-1:0]    seen_at [NumChan];
  logic [DistW-1:0]    report_mm [NumChan];

  report_t pending_reports[$];
  int      mismatches = 0;
  int      tx_quiet = 0;
  int      rx_quiet = 0;
  int      stall_left = 0;
  row_t    dir_tab [DirRows];
  logic [TimeW-1:0] clock_ms;
  logic    idle_mode = 1'b0;
  int      last_chan = 0;

  function automatic void reset_filter_model();
    jump_lim   = SpikeJumpRst;
    near_lim   = NearLimitRst;
    hold_max   = HoldCountRst;
    timeout_ms = StaleTimeoutRst;
    for (int c = 0; c < NumChan; c++) begin
      for (int k = 0; k < Window; k++) begin
        ring_mm[c][k] = '0;
      end
      ring_wr[c]   = '0;
      good_mm[c]   = FarMm;
      run_len[c]   = '0;
      seen_at[c]   = '0;
      report_mm[c] = FarMm;
    end
  endfunction

  function automatic logic [DistW-1:0] mid_of(logic [DistW-1:0] a, logic [DistW-1:0] b,
                                              logic [DistW-1:0] c);
    logic [DistW-1:0] lo;
    logic [DistW-1:0] hi;
    logic [DistW-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  function automatic report_t filter_poll(poll_t p);
    report_t          r;
    logic [DistW-1:0] lg;
    logic             rise;
    int               c;
    r.chan    = p.chan;
    r.dist_mm = FarMm;
    r.held    = 1'b0;
    r.stale   = 1'b0;
    c = int'(p.chan);
    if (c < NumChan) begin
      if (p.sv) begin
        if (p.med) begin
          ring_mm[c][ring_wr[c]] = p.raw;
          ring_wr[c] = (ring_wr[c] >= Window - 1) ? '0 : ring_wr[c] + 1'b1;
          r.dist_mm = mid_of(ring_mm[c][0], ring_mm[c][1], ring_mm[c][2]);
          good_mm[c] = r.dist_mm;
        end else begin
          lg = good_mm[c];
          rise = (p.raw > lg) && ((p.raw - lg) > jump_lim);
          if (rise && lg < near_lim) begin
            if (run_len[c] != RunMax) run_len[c] = run_len[c] + 1'b1;
            if (run_len[c] <= hold_max) begin
              r.dist_mm = lg;
              r.held = 1'b1;
            end else begin
              good_mm[c] = p.raw;
              r.dist_mm = p.raw;
            end
          end else begin
            run_len[c] = '0;
            good_mm[c] = p.raw;
            r.dist_mm = p.raw;
          end
        end
        report_mm[c] = r.dist_mm;
        seen_at[c] = p.now;
      end else begin
        if (seen_at[c] != '0 && (p.now - seen_at[c]) > timeout_ms) begin
          report_mm[c] = FarMm;
          r.stale = 1'b1;
        end
        r.dist_mm = report_mm[c];
      end
    end
    return r;
  endfunction

  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic poll_t next_poll();
    poll_t            p;
    logic [DistW-1:0] lg;
    int               v;
    if ($urandom_range(0, 24) == 0) idle_mode = ~idle_mode;
    if ($urandom_range(0, 19) == 0) begin
      p.chan = ChanW'($urandom_range(NumChan, 7));
    end else if ($urandom_range(0, 9) < 6) begin
      p.chan = ChanW'(last_chan);
    end else begin
      p.chan = ChanW'($urandom_range(0, NumChan - 1));
      last_chan = int'(p.chan);
    end
    case ($urandom_range(0, 19))
      0:       clock_ms = $urandom();
      1:       clock_ms = '0;
      2, 3:    clock_ms = clock_ms + timeout_ms + $urandom_range(0, 3);
      default: clock_ms = clock_ms + $urandom_range(0, timeout_ms / 8 + 2);
    endcase
    lg = (int'(p.chan) < NumChan) ? good_mm[p.chan] : FarMm;
    case ($urandom_range(0, 9))
      0, 1:    v = int'(lg) - 50 + int'($urandom_range(0, 100));
      2, 3:    v = int'(lg) + int'(jump_lim) + 1 + int'($urandom_range(0, 200));
      4:       v = int'(lg) + int'(jump_lim);
      5:       v = ($urandom_range(0, 2) == 0) ? 0 : 8190 + int'($urandom_range(0, 1));
      6, 7:    v = int'($urandom_range(0, near_lim));
      default: v = int'($urandom_range(0, 8191));
    endcase
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    p.raw = DistW'(v);
    p.sv  = ($urandom_range(0, 4) != 0);
    p.med = idle_mode ^ ($urandom_range(0, 19) == 0);
    p.now = clock_ms;
    return p;
  endfunction

  task automatic send_poll(input poll_t p, input logic typed, input report_t want);
    int gap;
    report_t r;
    gap = draw_gap(tx_quiet);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    chan_i         <= p.chan;
    sample_valid_i <= p.sv;
    raw_mm_i       <= p.raw;
    median_mode_i  <= p.med;
    now_ms_i       <= p.now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = filter_poll(p);
    pending_reports.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_limits(input logic [CfgDataW-1:0] jump, input logic [CfgDataW-1:0] near,
                                input logic [CfgDataW-1:0] hold, input logic [CfgDataW-1:0] tmo);
    logic [CfgDataW-1:0] vals [4];
    cfg_reg_e            idx;
    vals[0] = jump;
    vals[1] = near;
    vals[2] = hold;
    vals[3] = tmo;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_reg_e'(k);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx)
        REG_SPIKE_JUMP:    jump_lim   = vals[k][DistW-1:0];
        REG_NEAR_LIMIT:    near_lim   = vals[k][DistW-1:0];
        REG_HOLD_COUNT:    hold_max   = vals[k][RunW-1:0];
        REG_STALE_TIMEOUT: timeout_ms = vals[k][TimeoutW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    report_t w;
    if (out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual chan %0d dist %0d",
                 $time, out_chan_o, dist_mm_o);
        mismatches++;
      end else begin
        w = pending_reports.pop_front();
        check_field("out_chan", w.chan, out_chan_o);
        check_field("dist_mm", w.dist_mm, dist_mm_o);
        check_field("spike_held", w.held, spike_held_o);
        check_field("stale", w.stale, stale_o);
      end
      stall_left = draw_gap(rx_quiet);
      out_stall_i <= (stall_left != 0);
    end else if (out_stall_i) begin
      stall_left--;
      if (stall_left <= 0) out_stall_i <= 1'b0;
    end
  end

  initial begin
    poll_t   p;
    report_t want;
    int      useful;
    dir_tab = '{
      '{0, 0, 0,    0, 0,            1, FarMm, 0, 0},
      '{5, 1, 0,    0, 5,            1, FarMm, 0, 0},
      '{7, 1, 8191, 1, 9,            1, FarMm, 0, 0},
      '{0, 1, 100,  0, 1000,         1, 100,   0, 0},
      '{0, 1, 900,  0, 1001,         1, 100,   1, 0},
      '{0, 1, 8191, 0, 1002,         1, 100,   1, 0},
      '{0, 1, 900,  0, 1003,         1, 900,   0, 0},
      '{0, 0, 0,    0, 1203,         1, 900,   0, 0},
      '{0, 0, 8191, 1, 1204,         1, FarMm, 0, 1},
      '{0, 0, 0,    0, 1205,         1, FarMm, 0, 1},
      '{0, 1, 1600, 0, 1206,         0, 0,     0, 0},
      '{0, 1, 950,  0, 1207,         0, 0,     0, 0},
      '{1, 1, 8191, 1, 2000,         0, 0,     0, 0},
      '{1, 1, 0,    1, 2001,         0, 0,     0, 0},
      '{1, 1, 500,  1, 2002,         0, 0,     0, 0},
      '{1, 1, 7000, 1, 2003,         0, 0,     0, 0},
      '{1, 0, 0,    1, 2004,         0, 0,     0, 0},
      '{2, 1, 42,   0, 0,            1, 42,    0, 0},
      '{2, 0, 0,    0, 32'hFFFFFFFF, 1, 42,    0, 0},
      '{3, 1, 8191, 0, 32'hFFFFFFF0, 1, 8191,  0, 0},
      '{3, 0, 0,    0, 32'h00000010, 1, 8191,  0, 0},
      '{3, 0, 0,    0, 32'h000000B9, 0, 0,     0, 0},
      '{4, 1, 0,    0, 3000,         1, 0,     0, 0},
      '{4, 1, 401,  0, 3001,         0, 0,     0, 0},
      '{4, 1, 400,  0, 3002,         0, 0,     0, 0}
    };
    reset_filter_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      p    = '{dir_tab[i].chan, dir_tab[i].sv, dir_tab[i].raw, dir_tab[i].med, dir_tab[i].now};
      want = '{dir_tab[i].chan, dir_tab[i].dist_mm, dir_tab[i].held, dir_tab[i].stale};
      send_poll(p, dir_tab[i].typed, want);
    end

    clock_ms = 32'd5000;
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1: program_limits(16'd0, 16'd8191, 16'd15, 16'd0);
          2: program_limits(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
          3: program_limits(16'd50, 16'd3000, 16'd3, 16'd20);
          default: program_limits(CfgDataW'($urandom_range(0, 1500)),
                                  CfgDataW'($urandom_range(0, 8191)),
                                  CfgDataW'($urandom_range(0, 15)),
                                  CfgDataW'($urandom_range(0, 300)));
        endcase
      end
      useful = 0;
      while (useful < PollsPerPhase) begin
        p = next_poll();
        if (int'(p.chan) < NumChan) useful++;
        send_poll(p, 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tdsf_pkg.sv
design/tdsf_step.sv
design/tof_distance_spike_filter_unit.sv
verif/tb_tof_distance_spike_filter_unit.sv
